>>> rtl/core/fogc_pkg.sv
// Shared constants, types and state codes of the greedy segment orderer.
`default_nettype none

package fogc_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int SWAP_PASSES  = 8;
    localparam int PASS_W       = $clog2(SWAP_PASSES + 1);

    localparam int OFF_W        = 64;
    localparam int SC_W         = 17;
    localparam int WEIGHT_W     = 16;
    localparam int OUT_IDX_W    = 6;
    localparam int FIRST_W      = 20;
    localparam int PROD_W       = 35;
    localparam int SCORE_W      = 37;
    localparam int SUM_W        = 38;
    localparam int ACC_W        = 48;
    localparam int TOTAL_W      = 23;
    localparam int TOTAL_SHIFT  = 17;
    localparam int NEAR_WIN_BITS = 20;
    localparam int CFG_IDX_W    = 8;

    localparam logic [SC_W-1:0]    Q16_ONE      = 17'd65536;
    localparam logic [SC_W-1:0]    NEAR_PARTIAL = 17'd39322;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = 23'd8388607;

    localparam logic [WEIGHT_W-1:0] WN_RESET = 16'd16384;
    localparam logic [WEIGHT_W-1:0] WL_RESET = 16'd9830;
    localparam logic [WEIGHT_W-1:0] WS_RESET = 16'd26214;
    localparam logic [WEIGHT_W-1:0] WT_RESET = 16'd13107;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_NEAR    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LENGTH  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_STREAM  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TEXTURE = 8'd3;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [OFF_W-1:0] length;
        logic [SC_W-1:0]  stream;
        logic [SC_W-1:0]  texture;
    } seg_rec_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] near;
        logic [WEIGHT_W-1:0] length;
        logic [WEIGHT_W-1:0] stream;
        logic [WEIGHT_W-1:0] texture;
    } weights_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [SCORE_W-1:0] score;
    } pair_rsp_t;

    typedef enum logic [2:0] {
        PS_IDLE, PS_END, PS_DIFF, PS_NEAR, PS_DIV, PS_MUL, PS_DONE
    } pair_state_t;

    typedef enum logic [4:0] {
        ST_LOAD, ST_FIRST_RD, ST_FIRST_CMP,
        ST_GR_RD, ST_GR_START, ST_GR_RUN,
        ST_SW_INIT, ST_SW_P, ST_SW_C, ST_SW_NX_RD, ST_SW_NX,
        ST_SW_RD, ST_SW_START, ST_SW_RUN, ST_SW_DEC, ST_SW_WR2, ST_SW_NEXT,
        ST_EM_RD, ST_EM_LD, ST_EM_WAIT
    } top_state_t;

endpackage

`default_nettype wire

>>> rtl/core/fragment_order_greedy_chain.sv
// Top level of the greedy segment orderer: load, order, swap refine, emit.
//
// Usage
//   Input channel (in_valid/in_ready): one item per data segment, stored at
//   the next load position. An item with last_segment set closes the set and
//   starts ordering; up to 64 segments are kept, further items are dropped
//   and flag overflowed on every result of that set.
//   Output channel (out_valid/out_ready): one item per stored segment in the
//   chosen order; last_in_order marks the final one, which alone carries
//   plan_score.
//   Config channel (cfg_valid/cfg_ready, always ready): writes the four
//   Q0.16 weights; write only while the block is idle.
// Sequence
//   in_ready stays high while loading. The start pick reads each segment
//   in turn. Ordering is set by the shared pair score unit: each pair score
//   is a read, a start and a run in the unit, and the division is skipped
//   when the lengths are equal or both zero. Roughly N*N/2 scores for the
//   greedy chain plus 4*(N-2) per swap pass (up to 8 passes). Each result
//   then goes through the order memory read port and output register.
// Reset: weights return to defaults, the set is empty, no result pending.
// A stalled receiver holds the output register; no new set is loaded until
// the whole order has been taken.
`default_nettype none

module fragment_order_greedy_chain (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [fogc_pkg::OFF_W-1:0]       segment_offset,
    input  wire logic [fogc_pkg::OFF_W-1:0]       segment_length,
    input  wire logic [fogc_pkg::SC_W-1:0]        stream_score,
    input  wire logic [fogc_pkg::SC_W-1:0]        texture_score,
    input  wire logic                             last_segment,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [fogc_pkg::OUT_IDX_W-1:0]        segment_index,
    output logic                                  last_in_order,
    output logic [fogc_pkg::TOTAL_W-1:0]          plan_score,
    output logic                                  overflowed,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fogc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fogc_pkg::WEIGHT_W-1:0]    cfg_data
);

    localparam int IW = fogc_pkg::IDX_W;
    localparam int CW = fogc_pkg::CNT_W;

    // segment store and order store, registered reads
    fogc_pkg::seg_rec_t seg_mem [fogc_pkg::MAX_SEGMENTS];
    logic [IW-1:0]      ord_mem [fogc_pkg::MAX_SEGMENTS];

    fogc_pkg::seg_rec_t seg_rd_a_reg, seg_rd_b_reg, seg_wd;
    logic               seg_we;
    logic [IW-1:0]      seg_wa, seg_ra, seg_rb;
    logic [IW-1:0]      ord_rd_reg, ord_wd, ord_wa, ord_ra;
    logic               ord_we;

    fogc_pkg::top_state_t state_reg, state_next;
    fogc_pkg::weights_t   weights_reg, weights_next;

    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic                            ovf_reg, ovf_next;
    logic [fogc_pkg::MAX_SEGMENTS-1:0] used_reg, used_next;
    logic [fogc_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [CW-1:0]                   placed_reg, placed_next;
    logic [fogc_pkg::SCORE_W-1:0]    best_reg, best_next;
    logic [IW-1:0]                   best_idx_reg, best_idx_next;
    logic                            have_reg, have_next;
    logic [IW-1:0]                   prev_reg, prev_next;
    logic [IW-1:0]                   p_reg, p_next, c_reg, c_next, nx_reg, nx_next;
    logic [1:0]                      k_reg, k_next;
    logic [fogc_pkg::SUM_W-1:0]      cur_reg, cur_next, alt_reg, alt_next;
    logic [fogc_pkg::PASS_W-1:0]     pass_reg, pass_next;
    logic                            changed_reg, changed_next;

    logic                            out_valid_reg, out_valid_next;
    logic [fogc_pkg::OUT_IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic                            out_last_reg, out_last_next;
    logic [fogc_pkg::TOTAL_W-1:0]    out_total_reg, out_total_next;
    logic                            out_ovf_reg, out_ovf_next;

    logic                            pair_start;
    fogc_pkg::pair_rsp_t             pair_rsp;

    logic [fogc_pkg::FIRST_W-1:0]    first_score;
    logic [fogc_pkg::TOTAL_W-1:0]    total_sat;
    logic                            emit_last;

    fogc_pair_unit u_pair (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (pair_start),
        .rec_a   (seg_rd_a_reg),
        .rec_b   (seg_rd_b_reg),
        .weights (weights_reg),
        .rsp     (pair_rsp)
    );

    always_comb
    begin
        first_score = fogc_pkg::FIRST_W'(5) * fogc_pkg::FIRST_W'(seg_rd_a_reg.stream)
                    + fogc_pkg::FIRST_W'(seg_rd_a_reg.texture);
        // saturate the Q.16 plan score
        if (acc_reg[fogc_pkg::ACC_W-1:fogc_pkg::TOTAL_SHIFT+fogc_pkg::TOTAL_W] != '0)
            total_sat = fogc_pkg::TOTAL_MAX;
        else
            total_sat = acc_reg[fogc_pkg::TOTAL_SHIFT +: fogc_pkg::TOTAL_W];
        emit_last = (CW'(idx_reg + 1'b1) == cnt_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        weights_next   = weights_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        used_next      = used_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        placed_next    = placed_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        have_next      = have_reg;
        prev_next      = prev_reg;
        p_next         = p_reg;
        c_next         = c_reg;
        nx_next        = nx_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        alt_next       = alt_reg;
        pass_next      = pass_reg;
        changed_next   = changed_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_total_next = out_total_reg;
        out_ovf_next   = out_ovf_reg;

        in_ready   = 1'b0;
        pair_start = 1'b0;
        seg_we     = 1'b0;
        seg_wa     = cnt_reg[IW-1:0];
        seg_wd     = '{offset: segment_offset, length: segment_length,
                       stream: stream_score, texture: texture_score};
        seg_ra     = prev_reg;
        seg_rb     = idx_reg[IW-1:0];
        ord_we     = 1'b0;
        ord_wa     = idx_reg[IW-1:0];
        ord_wd     = nx_reg;
        ord_ra     = idx_reg[IW-1:0];

        // weight writes, low 16 bits kept, unknown index ignored
        if (cfg_valid)
        begin
            unique case (cfg_index)
                fogc_pkg::CFG_WEIGHT_NEAR:    weights_next.near    = cfg_data;
                fogc_pkg::CFG_WEIGHT_LENGTH:  weights_next.length  = cfg_data;
                fogc_pkg::CFG_WEIGHT_STREAM:  weights_next.stream  = cfg_data;
                fogc_pkg::CFG_WEIGHT_TEXTURE: weights_next.texture = cfg_data;
                default:                      weights_next         = weights_reg;
            endcase
        end

        unique case (state_reg)
            fogc_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cnt_reg != CW'(fogc_pkg::MAX_SEGMENTS))
                    begin
                        seg_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_segment)
                    begin
                        idx_next   = '0;
                        have_next  = 1'b0;
                        state_next = fogc_pkg::ST_FIRST_RD;
                    end
                end
            end

            // start segment: highest 5*stream + texture
            fogc_pkg::ST_FIRST_RD:
            begin
                seg_ra     = idx_reg[IW-1:0];
                state_next = fogc_pkg::ST_FIRST_CMP;
            end
            fogc_pkg::ST_FIRST_CMP:
            begin
                if (!have_reg || fogc_pkg::SCORE_W'(first_score) > best_reg)
                begin
                    best_next     = fogc_pkg::SCORE_W'(first_score);
                    best_idx_next = idx_reg[IW-1:0];
                    have_next     = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (emit_last)
                begin
                    ord_we      = 1'b1;
                    ord_wa      = '0;
                    ord_wd      = best_idx_next;
                    used_next[best_idx_next] = 1'b1;
                    prev_next   = best_idx_next;
                    placed_next = CW'(1);
                    idx_next    = '0;
                    have_next   = 1'b0;
                    if (cnt_reg == CW'(1))
                        state_next = fogc_pkg::ST_EM_RD;
                    else
                        state_next = fogc_pkg::ST_GR_RD;
                end
                else
                begin
                    state_next = fogc_pkg::ST_FIRST_RD;
                end
            end

            // greedy chain: scan unused candidates against the last placed one
            fogc_pkg::ST_GR_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    ord_we      = 1'b1;
                    ord_wa      = placed_reg[IW-1:0];
                    ord_wd      = best_idx_reg;
                    used_next[best_idx_reg] = 1'b1;
                    acc_next    = acc_reg + fogc_pkg::ACC_W'(best_reg);
                    prev_next   = best_idx_reg;
                    placed_next = placed_reg + 1'b1;
                    idx_next    = '0;
                    have_next   = 1'b0;
                    if (CW'(placed_reg + 1'b1) != cnt_reg)
                        state_next = fogc_pkg::ST_GR_RD;
                    else if (cnt_reg > CW'(2))
                    begin
                        pass_next  = '0;
                        state_next = fogc_pkg::ST_SW_INIT;
                    end
                    else
                        state_next = fogc_pkg::ST_EM_RD;
                end
                else if (used_reg[idx_reg[IW-1:0]])
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    seg_ra     = prev_reg;
                    seg_rb     = idx_reg[IW-1:0];
                    state_next = fogc_pkg::ST_GR_START;
                end
            end
            fogc_pkg::ST_GR_START:
            begin
                pair_start = 1'b1;
                state_next = fogc_pkg::ST_GR_RUN;
            end
            fogc_pkg::ST_GR_RUN:
            begin
                if (pair_rsp.done)
                begin
                    if (!have_reg || pair_rsp.score > best_reg)
                    begin
                        best_next     = pair_rsp.score;
                        best_idx_next = idx_reg[IW-1:0];
                        have_next     = 1'b1;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = fogc_pkg::ST_GR_RD;
                end
            end

            // swap passes: window p, c, nx slides along the order
            fogc_pkg::ST_SW_INIT:
            begin
                ord_ra       = '0;
                changed_next = 1'b0;
                idx_next     = CW'(1);
                state_next   = fogc_pkg::ST_SW_P;
            end
            fogc_pkg::ST_SW_P:
            begin
                p_next     = ord_rd_reg;
                ord_ra     = IW'(1);
                state_next = fogc_pkg::ST_SW_C;
            end
            fogc_pkg::ST_SW_C:
            begin
                c_next     = ord_rd_reg;
                state_next = fogc_pkg::ST_SW_NX_RD;
            end
            fogc_pkg::ST_SW_NX_RD:
            begin
                ord_ra     = IW'(idx_reg + 1'b1);
                state_next = fogc_pkg::ST_SW_NX;
            end
            fogc_pkg::ST_SW_NX:
            begin
                nx_next    = ord_rd_reg;
                k_next     = '0;
                cur_next   = '0;
                alt_next   = '0;
                state_next = fogc_pkg::ST_SW_RD;
            end
            fogc_pkg::ST_SW_RD:
            begin
                // pairs: (p,c) (c,nx) for the current order, (p,nx) (nx,c) swapped
                unique case (k_reg)
                    2'd0:
                    begin
                        seg_ra = p_reg;
                        seg_rb = c_reg;
                    end
                    2'd1:
                    begin
                        seg_ra = c_reg;
                        seg_rb = nx_reg;
                    end
                    2'd2:
                    begin
                        seg_ra = p_reg;
                        seg_rb = nx_reg;
                    end
                    default:
                    begin
                        seg_ra = nx_reg;
                        seg_rb = c_reg;
                    end
                endcase
                state_next = fogc_pkg::ST_SW_START;
            end
            fogc_pkg::ST_SW_START:
            begin
                pair_start = 1'b1;
                state_next = fogc_pkg::ST_SW_RUN;
            end
            fogc_pkg::ST_SW_RUN:
            begin
                if (pair_rsp.done)
                begin
                    if (!k_reg[1])
                        cur_next = cur_reg + fogc_pkg::SUM_W'(pair_rsp.score);
                    else
                        alt_next = alt_reg + fogc_pkg::SUM_W'(pair_rsp.score);
                    k_next = k_reg + 1'b1;
                    if (k_reg == 2'd3)
                        state_next = fogc_pkg::ST_SW_DEC;
                    else
                        state_next = fogc_pkg::ST_SW_RD;
                end
            end
            fogc_pkg::ST_SW_DEC:
            begin
                if (alt_reg > cur_reg)
                begin
                    ord_we       = 1'b1;
                    ord_wa       = idx_reg[IW-1:0];
                    ord_wd       = nx_reg;
                    acc_next     = acc_reg + fogc_pkg::ACC_W'(alt_reg - cur_reg);
                    changed_next = 1'b1;
                    p_next       = nx_reg;
                    state_next   = fogc_pkg::ST_SW_WR2;
                end
                else
                begin
                    p_next     = c_reg;
                    c_next     = nx_reg;
                    state_next = fogc_pkg::ST_SW_NEXT;
                end
            end
            fogc_pkg::ST_SW_WR2:
            begin
                ord_we     = 1'b1;
                ord_wa     = IW'(idx_reg + 1'b1);
                ord_wd     = c_reg;
                state_next = fogc_pkg::ST_SW_NEXT;
            end
            fogc_pkg::ST_SW_NEXT:
            begin
                idx_next = idx_reg + 1'b1;
                if ((CW+1)'(idx_reg) + (CW+1)'(2) < (CW+1)'(cnt_reg))
                    state_next = fogc_pkg::ST_SW_NX_RD;
                else
                begin
                    pass_next = pass_reg + 1'b1;
                    idx_next  = '0;
                    if (!changed_reg ||
                        (pass_reg + 1'b1) == fogc_pkg::PASS_W'(fogc_pkg::SWAP_PASSES))
                        state_next = fogc_pkg::ST_EM_RD;
                    else
                        state_next = fogc_pkg::ST_SW_INIT;
                end
            end

            // emit one index per result through the output register
            fogc_pkg::ST_EM_RD:
            begin
                ord_ra     = idx_reg[IW-1:0];
                state_next = fogc_pkg::ST_EM_LD;
            end
            fogc_pkg::ST_EM_LD:
            begin
                out_valid_next = 1'b1;
                out_idx_next   = fogc_pkg::OUT_IDX_W'(ord_rd_reg);
                out_last_next  = emit_last;
                out_total_next = emit_last ? total_sat : '0;
                out_ovf_next   = ovf_reg;
                state_next     = fogc_pkg::ST_EM_WAIT;
            end
            fogc_pkg::ST_EM_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        cnt_next   = '0;
                        used_next  = '0;
                        acc_next   = '0;
                        ovf_next   = 1'b0;
                        idx_next   = '0;
                        state_next = fogc_pkg::ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = fogc_pkg::ST_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = fogc_pkg::ST_LOAD;
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (seg_we)
            seg_mem[seg_wa] <= seg_wd;
        seg_rd_a_reg <= seg_mem[seg_ra];
        seg_rd_b_reg <= seg_mem[seg_rb];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
        ord_rd_reg <= ord_mem[ord_ra];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fogc_pkg::ST_LOAD;
            weights_reg   <= '{near: fogc_pkg::WN_RESET, length: fogc_pkg::WL_RESET,
                               stream: fogc_pkg::WS_RESET, texture: fogc_pkg::WT_RESET};
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            used_reg      <= '0;
            acc_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            weights_reg   <= weights_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            used_reg      <= used_next;
            acc_reg       <= acc_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        placed_reg    <= placed_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        have_reg      <= have_next;
        prev_reg      <= prev_next;
        p_reg         <= p_next;
        c_reg         <= c_next;
        nx_reg        <= nx_next;
        k_reg         <= k_next;
        cur_reg       <= cur_next;
        alt_reg       <= alt_next;
        pass_reg      <= pass_next;
        changed_reg   <= changed_next;
        out_idx_reg   <= out_idx_next;
        out_last_reg  <= out_last_next;
        out_total_reg <= out_total_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign segment_index = out_idx_reg;
    assign last_in_order = out_last_reg;
    assign plan_score    = out_total_reg;
    assign overflowed    = out_ovf_reg;

    a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == fogc_pkg::ST_EM_WAIT)
        else $error("result shown outside the emit wait state");

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(fogc_pkg::MAX_SEGMENTS))
        else $error("load count beyond capacity");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        pair_start |-> !pair_rsp.busy)
        else $error("pair unit started while busy");

    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid_reg)
        else $error("input taken while a result is pending");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && out_last_reg) |=> (cnt_reg == '0 && used_reg == '0))
        else $error("set not cleared after the final result");

endmodule

`default_nettype wire

>>> rtl/core/fogc_pair_unit.sv
// Multi-cycle pair score unit: adjacency, serial length ratio, weighted sum.
`default_nettype none

module fogc_pair_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire fogc_pkg::seg_rec_t  rec_a,
    input  wire fogc_pkg::seg_rec_t  rec_b,
    input  wire fogc_pkg::weights_t  weights,
    output fogc_pkg::pair_rsp_t      rsp
);

    fogc_pkg::pair_state_t state_reg, state_next;

    fogc_pkg::seg_rec_t a_reg, a_next, b_reg, b_next;
    logic [fogc_pkg::OFF_W-1:0]   end_reg, end_next, d_reg, d_next;
    logic [fogc_pkg::OFF_W-1:0]   lo_reg, lo_next, hi_reg, hi_next, r_reg, r_next;
    logic [fogc_pkg::SC_W-1:0]    near_reg, near_next, q_reg, q_next;
    logic [3:0]                   div_cnt_reg, div_cnt_next;
    logic [2:0]                   mul_cnt_reg, mul_cnt_next;
    logic [fogc_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [fogc_pkg::SCORE_W-1:0] acc_reg, acc_next;

    logic [fogc_pkg::OFF_W:0]     r_shift, r_sub;
    logic [fogc_pkg::OFF_W-1:0]   d_neg;
    logic [fogc_pkg::WEIGHT_W-1:0] mul_w;
    logic [fogc_pkg::SC_W:0]      mul_x;
    logic                         mul_dbl;
    logic [fogc_pkg::PROD_W-2:0]  mul_raw;

    always_comb
    begin
        r_shift = {r_reg, 1'b0};
        r_sub   = r_shift - {1'b0, hi_reg};
        d_neg   = '0 - d_reg;

        mul_w   = '0;
        mul_x   = '0;
        mul_dbl = 1'b0;
        unique case (mul_cnt_reg)
            3'd0:
            begin
                mul_w   = weights.near;
                mul_x   = {1'b0, near_reg};
                mul_dbl = 1'b1;
            end
            3'd1:
            begin
                mul_w   = weights.length;
                mul_x   = {1'b0, q_reg};
                mul_dbl = 1'b1;
            end
            3'd2:
            begin
                mul_w = weights.stream;
                mul_x = {1'b0, a_reg.stream} + {1'b0, b_reg.stream};
            end
            3'd3:
            begin
                mul_w = weights.texture;
                mul_x = {1'b0, a_reg.texture} + {1'b0, b_reg.texture};
            end
            default:
            begin
                mul_w = '0;
            end
        endcase
        mul_raw = mul_w * mul_x;
    end

    always_comb
    begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        end_next     = end_reg;
        d_next       = d_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        r_next       = r_reg;
        near_next    = near_reg;
        q_next       = q_reg;
        div_cnt_next = div_cnt_reg;
        mul_cnt_next = mul_cnt_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;

        unique case (state_reg)
            fogc_pkg::PS_IDLE:
            begin
                if (start)
                begin
                    a_next     = rec_a;
                    b_next     = rec_b;
                    state_next = fogc_pkg::PS_END;
                end
            end
            fogc_pkg::PS_END:
            begin
                end_next = a_reg.offset + a_reg.length;
                if (a_reg.length < b_reg.length)
                begin
                    lo_next = a_reg.length;
                    hi_next = b_reg.length;
                end
                else
                begin
                    lo_next = b_reg.length;
                    hi_next = a_reg.length;
                end
                state_next = fogc_pkg::PS_DIFF;
            end
            fogc_pkg::PS_DIFF:
            begin
                d_next       = end_reg - b_reg.offset;
                r_next       = lo_reg;
                q_next       = '0;
                div_cnt_next = '0;
                state_next   = fogc_pkg::PS_NEAR;
            end
            fogc_pkg::PS_NEAR:
            begin
                if (d_reg == '0)
                    near_next = fogc_pkg::Q16_ONE;
                else if (d_reg[fogc_pkg::OFF_W-1:fogc_pkg::NEAR_WIN_BITS] == '0 ||
                         d_neg[fogc_pkg::OFF_W-1:fogc_pkg::NEAR_WIN_BITS] == '0)
                    near_next = fogc_pkg::NEAR_PARTIAL;
                else
                    near_next = '0;
                mul_cnt_next = '0;
                acc_next     = '0;
                // zero and equal lengths need no division
                if (hi_reg == '0)
                begin
                    q_next     = '0;
                    state_next = fogc_pkg::PS_MUL;
                end
                else if (lo_reg == hi_reg)
                begin
                    q_next     = fogc_pkg::Q16_ONE;
                    state_next = fogc_pkg::PS_MUL;
                end
                else
                begin
                    state_next = fogc_pkg::PS_DIV;
                end
            end
            fogc_pkg::PS_DIV:
            begin
                if (!r_sub[fogc_pkg::OFF_W])
                begin
                    r_next = r_sub[fogc_pkg::OFF_W-1:0];
                    q_next = {q_reg[fogc_pkg::SC_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = r_shift[fogc_pkg::OFF_W-1:0];
                    q_next = {q_reg[fogc_pkg::SC_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15)
                    state_next = fogc_pkg::PS_MUL;
            end
            fogc_pkg::PS_MUL:
            begin
                if (mul_cnt_reg != 3'd4)
                    prod_next = mul_dbl ? {mul_raw, 1'b0} : {1'b0, mul_raw};
                if (mul_cnt_reg != 3'd0)
                    acc_next = acc_reg + fogc_pkg::SCORE_W'(prod_reg);
                mul_cnt_next = mul_cnt_reg + 3'd1;
                if (mul_cnt_reg == 3'd4)
                    state_next = fogc_pkg::PS_DONE;
            end
            fogc_pkg::PS_DONE:
            begin
                state_next = fogc_pkg::PS_IDLE;
            end
            default:
            begin
                state_next = fogc_pkg::PS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fogc_pkg::PS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        end_reg     <= end_next;
        d_reg       <= d_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        r_reg       <= r_next;
        near_reg    <= near_next;
        q_reg       <= q_next;
        div_cnt_reg <= div_cnt_next;
        mul_cnt_reg <= mul_cnt_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
    end

    assign rsp.busy  = (state_reg != fogc_pkg::PS_IDLE);
    assign rsp.done  = (state_reg == fogc_pkg::PS_DONE);
    assign rsp.score = acc_reg;

endmodule

`default_nettype wire
